[hw/rtl/dtq_pkg.sv]
// ----------------------------------------------------------------------------
// dtq_pkg
// shared types and codes for the deadline timer queue
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int TID_W       = 16;
    localparam int TIME_W      = 64;
    localparam int CNT_W       = 6;
    localparam int MAX_RESULTS = 32;

    // configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_SEL_BIT = 3;
    localparam logic REG_IDLE_DELAY = 1'b0;
    localparam logic [TIME_W-1:0] IDLE_DELAY_RST = 64'd100000000;

    // operations
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_EXPIRE = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    // result status
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EXPIRED   = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;
    localparam logic [2:0] ST_DELAY     = 3'd6;

    typedef struct packed {
        logic [1:0]        op;
        logic [TID_W-1:0]  task_id;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] now;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [TID_W-1:0]  out_task_id;
        logic [TIME_W-1:0] delay;
        logic [CNT_W-1:0]  expired_count;
        logic              last;
    } t_out_item;

endpackage

[hw/rtl/dtq_store.sv]
// ----------------------------------------------------------------------------
// dtq_store
// entry memory: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module dtq_store #(
    parameter int DEPTH  = 32,
    parameter int ID_W   = 16,
    parameter int TIME_W = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [TIME_W-1:0]        i_wdl,
    input  logic [ID_W-1:0]          i_wid,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [TIME_W-1:0]        o_rdl,
    output logic [ID_W-1:0]          o_rid
);

    logic [TIME_W-1:0] r_mem_dl [DEPTH];
    logic [ID_W-1:0]   r_mem_id [DEPTH];
    logic [TIME_W-1:0] r_rdl;
    logic [ID_W-1:0]   r_rid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_dl[i_waddr] <= i_wdl;
            r_mem_id[i_waddr] <= i_wid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdl <= r_mem_dl[i_raddr];
        r_rid <= r_mem_id[i_raddr];
    end

    assign o_rdl = r_rdl;
    assign o_rid = r_rid;

endmodule

[hw/rtl/deadline_timer_queue.sv]
// ----------------------------------------------------------------------------
// deadline_timer_queue: sorted timer queue over an entry memory with one write and one read port
// each memory step is a read, a registered read, then one 64-bit compare/subtract;
// the sequencer stays busy after the transfer: insert moves later entries up one slot,
// cancel scans for the id and compacts behind it, expire examines the due entries and
// compacts the rest, query reads the head; a full expire is the slowest operation
// one item at a time, and results wait on output stalls; reset empties the queue, idle_delay 100000000
// ----------------------------------------------------------------------------
module deadline_timer_queue #(
    parameter int DEPTH   = 32,
    parameter int ID_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item channel
    input  logic                                i_in_valid,
    input  dtq_pkg::t_in_item                   i_in_data,
    output logic                                o_in_stall,
    // result channel
    output logic                                o_out_valid,
    output dtq_pkg::t_out_item                  o_out_data,
    input  logic                                i_out_stall,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dtq_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [dtq_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [dtq_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    import dtq_pkg::*;

    // stored id width: the input id is only 16 bits wide
    localparam int ID_W = (ID_BITS < TID_W) ? ID_BITS : TID_W;
    localparam int AW   = $clog2(DEPTH);
    localparam int OW   = $clog2(DEPTH + 1);
    localparam int LIM  = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
    localparam logic [OW-1:0] OCC_FULL = OW'(DEPTH);
    localparam logic [OW-1:0] EXP_LIM  = OW'(LIM);

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_CMP = 4'd2;
    localparam logic [3:0] S_INS_PUT = 4'd3;
    localparam logic [3:0] S_CAN_RD  = 4'd4;
    localparam logic [3:0] S_CAN_CMP = 4'd5;
    localparam logic [3:0] S_SHF_RD  = 4'd6;
    localparam logic [3:0] S_SHF_WR  = 4'd7;
    localparam logic [3:0] S_SHF_END = 4'd8;
    localparam logic [3:0] S_EXP_RD  = 4'd9;
    localparam logic [3:0] S_EXP_CMP = 4'd10;
    localparam logic [3:0] S_EXP_OUT = 4'd11;
    localparam logic [3:0] S_EXP_FIN = 4'd12;
    localparam logic [3:0] S_QRY_RD  = 4'd13;
    localparam logic [3:0] S_QRY_CMP = 4'd14;
    localparam logic [3:0] S_EMIT    = 4'd15;

    function automatic t_out_item mk_res(
        input logic [2:0]        st,
        input logic [TID_W-1:0]  tid,
        input logic [TIME_W-1:0] dly,
        input logic [CNT_W-1:0]  cnt,
        input logic              lst
    );
        t_out_item r;
        r.status        = st;
        r.out_task_id   = tid;
        r.delay         = dly;
        r.expired_count = cnt;
        r.last          = lst;
        return r;
    endfunction

    // control state
    logic [3:0]        r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [OW-1:0]     r_idx, n_idx;    // walking entry index
    logic [OW-1:0]     r_dist, n_dist;  // compaction distance
    logic [OW-1:0]     r_occ, n_occ;    // entries held
    logic              r_out_valid, n_out_valid;
    logic [TIME_W-1:0] r_idle_delay;

    // payload state
    logic [ID_W-1:0]   r_id, n_id;
    logic [TIME_W-1:0] r_key, n_key;    // deadline for insert, now otherwise
    logic [ID_W-1:0]   r_pend, n_pend;  // due entry waiting to be reported
    logic [ID_W-1:0]   r_nid, n_nid;
    logic              r_due, n_due;
    t_out_item         r_res, n_res;
    t_out_item         r_out;

    // memory port signals
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [TIME_W-1:0] mem_wdl;
    logic [ID_W-1:0]   mem_wid;
    logic [AW-1:0]     mem_raddr;
    logic [TIME_W-1:0] rd_dl;
    logic [ID_W-1:0]   rd_id;

    // shared subtract unit
    logic [TIME_W-1:0] sub_a, sub_b;
    logic [TIME_W:0]   sub_diff;
    logic              sub_borrow;

    logic              out_free, out_load;
    t_out_item         out_item;
    logic [OW-1:0]     idx_p1, idx_m1, idx_dst;
    logic              exp_more;
    logic [TID_W-1:0]  in_id_ext;
    logic              cfg_wr;

    dtq_store #(
        .DEPTH (DEPTH),
        .ID_W  (ID_W),
        .TIME_W(TIME_W)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdl  (mem_wdl),
        .i_wid  (mem_wid),
        .i_raddr(mem_raddr),
        .o_rdl  (rd_dl),
        .o_rid  (rd_id)
    );

    // query works on deadline minus now, every other compare on key minus deadline;
    // a borrow means the left operand is the smaller one
    assign sub_a      = (r_state == S_QRY_CMP) ? rd_dl : r_key;
    assign sub_b      = (r_state == S_QRY_CMP) ? r_key : rd_dl;
    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[TIME_W];

    assign idx_p1   = r_idx + OW'(1);
    assign idx_m1   = r_idx - OW'(1);
    assign idx_dst  = r_idx - r_dist;
    // another candidate exists and the per-item pop limit is not reached
    assign exp_more = (idx_p1 < r_occ) && (idx_p1 < EXP_LIM);

    // output register frees up when empty or when its transfer completes
    assign out_free = !r_out_valid || !i_out_stall;

    assign in_id_ext = TID_W'(i_in_data.task_id[ID_W-1:0]);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_idx       = r_idx;
        n_dist      = r_dist;
        n_occ       = r_occ;
        n_id        = r_id;
        n_key       = r_key;
        n_pend      = r_pend;
        n_nid       = r_nid;
        n_due       = r_due;
        n_res       = r_res;
        out_load    = 1'b0;
        out_item    = r_res;
        mem_we      = 1'b0;
        mem_waddr   = r_idx[AW-1:0];
        mem_wdl     = rd_dl;
        mem_wid     = rd_id;
        mem_raddr   = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op  = i_in_data.op;
                    n_id  = i_in_data.task_id[ID_W-1:0];
                    n_key = (i_in_data.op == OP_INSERT) ? i_in_data.deadline
                                                        : i_in_data.now;
                    n_idx = '0;
                    unique case (i_in_data.op)
                        OP_INSERT: begin
                            if (r_occ == OCC_FULL) begin
                                n_res   = mk_res(ST_FULL, in_id_ext, '0, '0, 1'b1);
                                n_state = S_EMIT;
                            end else begin
                                // walk down from the top, moving later deadlines up
                                n_idx   = r_occ;
                                n_state = (r_occ == '0) ? S_INS_PUT : S_INS_RD;
                            end
                        end
                        OP_CANCEL: begin
                            if (r_occ == '0) begin
                                n_res   = mk_res(ST_NOT_FOUND, in_id_ext, '0, '0, 1'b1);
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_CAN_RD;
                            end
                        end
                        OP_EXPIRE: begin
                            if (r_occ == '0) begin
                                n_res   = mk_res(ST_NONE, '0, '0, '0, 1'b1);
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_EXP_RD;
                            end
                        end
                        OP_QUERY: begin
                            if (r_occ == '0) begin
                                n_res   = mk_res(ST_DELAY, '0, r_idle_delay, '0, 1'b1);
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_QRY_RD;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            // sorted insert
            S_INS_RD: begin
                mem_raddr = idx_m1[AW-1:0];
                n_state   = S_INS_CMP;
            end
            S_INS_CMP: begin
                mem_raddr = idx_m1[AW-1:0];
                if (sub_borrow) begin
                    // stored deadline is later: move it up one slot
                    mem_we  = 1'b1;
                    n_idx   = idx_m1;
                    n_state = (idx_m1 == '0) ? S_INS_PUT : S_INS_RD;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                mem_we  = 1'b1;
                mem_wdl = r_key;
                mem_wid = r_id;
                n_occ   = r_occ + OW'(1);
                n_res   = mk_res(ST_INSERTED, TID_W'(r_id), '0, '0, 1'b1);
                n_state = S_EMIT;
            end

            // cancel search
            S_CAN_RD: begin
                n_state = S_CAN_CMP;
            end
            S_CAN_CMP: begin
                if (rd_id == r_id) begin
                    n_dist  = OW'(1);
                    n_idx   = idx_p1;
                    n_state = (idx_p1 == r_occ) ? S_SHF_END : S_SHF_RD;
                end else if (idx_p1 == r_occ) begin
                    n_res   = mk_res(ST_NOT_FOUND, TID_W'(r_id), '0, '0, 1'b1);
                    n_state = S_EMIT;
                end else begin
                    n_idx   = idx_p1;
                    n_state = S_CAN_RD;
                end
            end

            // compaction: entry at r_idx moves down by r_dist
            S_SHF_RD: begin
                n_state = S_SHF_WR;
            end
            S_SHF_WR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_dst[AW-1:0];
                n_idx     = idx_p1;
                n_state   = (idx_p1 == r_occ) ? S_SHF_END : S_SHF_RD;
            end
            S_SHF_END: begin
                n_occ = r_occ - r_dist;
                if (r_op == OP_CANCEL) begin
                    n_res   = mk_res(ST_CANCELLED, TID_W'(r_id), '0, '0, 1'b1);
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end

            // expire drain: one entry held back until the next tells if it is last
            S_EXP_RD: begin
                n_state = S_EXP_CMP;
            end
            S_EXP_CMP: begin
                n_due   = !sub_borrow;
                n_nid   = rd_id;
                n_state = S_EXP_OUT;
            end
            S_EXP_OUT: begin
                if (r_idx == '0) begin
                    if (!r_due) begin
                        n_res   = mk_res(ST_NONE, '0, '0, '0, 1'b1);
                        n_state = S_EMIT;
                    end else begin
                        n_pend  = r_nid;
                        n_idx   = idx_p1;
                        n_state = exp_more ? S_EXP_RD : S_EXP_FIN;
                    end
                end else if (out_free) begin
                    out_load = 1'b1;
                    out_item = mk_res(ST_EXPIRED, TID_W'(r_pend), '0,
                                      CNT_W'(r_idx), !r_due);
                    if (r_due) begin
                        n_pend  = r_nid;
                        n_idx   = idx_p1;
                        n_state = exp_more ? S_EXP_RD : S_EXP_FIN;
                    end else begin
                        n_dist  = r_idx;
                        n_state = S_SHF_RD;
                    end
                end
            end
            S_EXP_FIN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_item = mk_res(ST_EXPIRED, TID_W'(r_pend), '0,
                                      CNT_W'(r_idx), 1'b1);
                    n_dist   = r_idx;
                    n_state  = (r_idx == r_occ) ? S_SHF_END : S_SHF_RD;
                end
            end

            // query of the head entry
            S_QRY_RD: begin
                mem_raddr = '0;
                n_state   = S_QRY_CMP;
            end
            S_QRY_CMP: begin
                mem_raddr = '0;
                n_res     = mk_res(ST_DELAY, '0,
                                   sub_borrow ? '0 : sub_diff[TIME_W-1:0], '0, 1'b1);
                n_state   = S_EMIT;
            end

            // single result waits for the output register
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_item = r_res;
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = out_load | (r_out_valid & i_out_stall);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_INSERT;
            r_idx       <= '0;
            r_dist      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_idx       <= n_idx;
            r_dist      <= n_dist;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_key  <= n_key;
        r_pend <= n_pend;
        r_nid  <= n_nid;
        r_due  <= n_due;
        r_res  <= n_res;
        if (out_load) begin
            r_out <= out_item;
        end
    end

    // configuration: one 64-bit register at byte address 0
    assign cfg_wr = psel && penable && pwrite && (paddr[CFG_SEL_BIT] == REG_IDLE_DELAY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_delay <= IDLE_DELAY_RST;
        end else if (cfg_wr) begin
            r_idle_delay <= pwdata;
        end
    end

    assign prdata = (paddr[CFG_SEL_BIT] == REG_IDLE_DELAY) ? r_idle_delay : '0;
    assign pready = 1'b1;

    // new item only while the sequencer is idle; a result held in the output register does not block it
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[test/dtq_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtq_checker
// watches the item channels and the register port of the deadline timer
// queue, keeps its own sorted copy of the timers and checks every result
// ----------------------------------------------------------------------------
module dtq_checker #(
    parameter int DEPTH   = 32,
    parameter int ID_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  dtq_pkg::t_in_item                i_in_data,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  dtq_pkg::t_out_item               i_out_data,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic                             i_pready,
    input  logic [dtq_pkg::CFG_ADDR_W-1:0]   i_paddr,
    input  logic [dtq_pkg::CFG_DATA_W-1:0]   i_pwdata,
    input  logic [dtq_pkg::CFG_DATA_W-1:0]   i_prdata,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_result_count
);
    import dtq_pkg::*;

    localparam logic [TID_W-1:0] ID_MASK = TID_W'((64'd1 << ID_BITS) - 64'd1);

    // sorted timers, earliest deadline first
    logic [TIME_W-1:0] timer_deadline [DEPTH];
    logic [TID_W-1:0]  timer_id [DEPTH];
    int                timer_fill = 0;
    logic [TIME_W-1:0] idle_delay_reg = IDLE_DELAY_RST;

    t_out_item         predicted_replies [$];
    t_out_item         oldest_reply;
    int                fail_count = 0;
    int                result_count = 0;

    task automatic note_failure(input string msg);
        if (fail_count < 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    function automatic t_out_item make_reply(input logic [2:0] status,
                                             input logic [TID_W-1:0] id,
                                             input logic [TIME_W-1:0] delay,
                                             input logic [CNT_W-1:0] count,
                                             input logic last);
        t_out_item r;
        r.status        = status;
        r.out_task_id   = id;
        r.delay         = delay;
        r.expired_count = count;
        r.last          = last;
        return r;
    endfunction

    task automatic apply_timer_op(input t_in_item it);
        logic [TID_W-1:0] tid;
        int               pos;
        int               n;
        int               i;
        tid = it.task_id & ID_MASK;
        case (it.op)
            OP_INSERT: begin
                if (timer_fill >= DEPTH) begin
                    predicted_replies.push_back(make_reply(ST_FULL, tid, '0, '0, 1'b1));
                end else begin
                    // lands behind every entry with the same deadline
                    pos = 0;
                    while (pos < timer_fill && timer_deadline[pos] <= it.deadline) pos++;
                    for (i = timer_fill; i > pos; i--) begin
                        timer_deadline[i] = timer_deadline[i-1];
                        timer_id[i]       = timer_id[i-1];
                    end
                    timer_deadline[pos] = it.deadline;
                    timer_id[pos]       = tid;
                    timer_fill++;
                    predicted_replies.push_back(make_reply(ST_INSERTED, tid, '0, '0, 1'b1));
                end
            end
            OP_CANCEL: begin
                pos = 0;
                while (pos < timer_fill && timer_id[pos] != tid) pos++;
                if (pos >= timer_fill) begin
                    predicted_replies.push_back(make_reply(ST_NOT_FOUND, tid, '0, '0, 1'b1));
                end else begin
                    for (i = pos; i + 1 < timer_fill; i++) begin
                        timer_deadline[i] = timer_deadline[i+1];
                        timer_id[i]       = timer_id[i+1];
                    end
                    timer_fill--;
                    predicted_replies.push_back(make_reply(ST_CANCELLED, tid, '0, '0, 1'b1));
                end
            end
            OP_EXPIRE: begin
                n = 0;
                while (n < timer_fill && n < MAX_RESULTS && timer_deadline[n] <= it.now) n++;
                if (n == 0) begin
                    predicted_replies.push_back(make_reply(ST_NONE, '0, '0, '0, 1'b1));
                end else begin
                    for (i = 0; i < n; i++) begin
                        predicted_replies.push_back(make_reply(ST_EXPIRED, timer_id[i], '0,
                                                               CNT_W'(i + 1), i == n - 1));
                    end
                    for (i = n; i < timer_fill; i++) begin
                        timer_deadline[i-n] = timer_deadline[i];
                        timer_id[i-n]       = timer_id[i];
                    end
                    timer_fill -= n;
                end
            end
            OP_QUERY: begin
                if (timer_fill == 0) begin
                    predicted_replies.push_back(make_reply(ST_DELAY, '0, idle_delay_reg, '0, 1'b1));
                end else if (it.now > timer_deadline[0]) begin
                    predicted_replies.push_back(make_reply(ST_DELAY, '0, '0, '0, 1'b1));
                end else begin
                    predicted_replies.push_back(make_reply(ST_DELAY, '0,
                                                           timer_deadline[0] - it.now, '0, 1'b1));
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timer_fill     = 0;
            idle_delay_reg = IDLE_DELAY_RST;
            predicted_replies.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                result_count++;
                if (predicted_replies.size() == 0) begin
                    note_failure($sformatf("unexpected result status %0d id %h delay %h cnt %0d",
                                           i_out_data.status, i_out_data.out_task_id,
                                           i_out_data.delay, i_out_data.expired_count));
                end else begin
                    oldest_reply = predicted_replies[0];
                    predicted_replies.delete(0);
                    if (i_out_data.status !== oldest_reply.status ||
                        i_out_data.out_task_id !== oldest_reply.out_task_id ||
                        i_out_data.delay !== oldest_reply.delay ||
                        i_out_data.expired_count !== oldest_reply.expired_count ||
                        i_out_data.last !== oldest_reply.last) begin
                        note_failure($sformatf({"result %0d: expected st %0d id %h dly %h cnt %0d",
                                                " last %b, got st %0d id %h dly %h cnt %0d last %b"},
                                               result_count, oldest_reply.status,
                                               oldest_reply.out_task_id, oldest_reply.delay,
                                               oldest_reply.expired_count, oldest_reply.last,
                                               i_out_data.status, i_out_data.out_task_id,
                                               i_out_data.delay, i_out_data.expired_count,
                                               i_out_data.last));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_timer_op(i_in_data);
            end
            if (i_psel && i_penable && i_pready && i_paddr[CFG_SEL_BIT] == REG_IDLE_DELAY) begin
                if (i_pwrite) begin
                    idle_delay_reg = i_pwdata;
                end else if (i_prdata !== idle_delay_reg) begin
                    note_failure($sformatf("idle_delay read %h, expected %h",
                                           i_prdata, idle_delay_reg));
                end
            end
        end
        o_pending      <= predicted_replies.size();
        o_result_count <= result_count;
        o_fail_count   <= fail_count;
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// directed and random timer operations against the deadline timer queue under
// three sender/receiver idle mixes, with idle_delay rewritten between phases
// ----------------------------------------------------------------------------
module testbench;
    import dtq_pkg::*;

    localparam int DEPTH        = 32;
    localparam int ID_BITS      = 16;
    localparam int DRAIN_CYCLES = 100;      // covers compaction after the last result
    localparam int LONG_HOLD    = 300;      // receiver hold-off, in cycles
    localparam int PHASE_ITEMS  = 110;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam logic [CFG_ADDR_W-1:0] IDLE_DELAY_ADDR = CFG_ADDR_W'(8 * int'(REG_IDLE_DELAY));

    // clock, reset and block ports
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_item              in_data = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_data;
    logic                  out_stall = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // checker status
    int fail_count;
    int pending;
    int result_count;

    // stimulus bookkeeping
    int                send_idle_pct = 19;
    int                recv_idle_pct = 78;
    int                hold_ticket = 0;
    int                hold_seen = 0;
    int                hold_left = 0;
    int                items_sent = 0;
    int                cfg_writes = 0;
    logic [TIME_W-1:0] sim_now = 64'd1000;
    logic [TIME_W-1:0] last_deadline = 64'd1000;
    logic [TID_W-1:0]  recent_ids [$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    deadline_timer_queue #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    dtq_checker #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) timer_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_data     (out_data),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // receiver side: random stall, or a long hold-off when the ticket moves
    always @(posedge clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic t_in_item mk_item(input logic [1:0] op, input logic [TID_W-1:0] id,
                                         input logic [TIME_W-1:0] dl,
                                         input logic [TIME_W-1:0] now_val);
        t_in_item it;
        it.op       = op;
        it.task_id  = id;
        it.deadline = dl;
        it.now      = now_val;
        return it;
    endfunction

    // one transfer on the item channel; valid stays up into the next item
    // unless the sender decides to idle
    task automatic offer_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // stop sending, wait for every outstanding result, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write followed by a readback, back to back on the bus
    task automatic write_idle_delay(input logic [TIME_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= IDLE_DELAY_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_writes++;
    endtask

    // pushes the store past full, then drains a full store in one expire
    task automatic fill_and_flush();
        repeat (DEPTH + 2) begin
            offer_item(mk_item(OP_INSERT, TID_W'($urandom), sim_now + $urandom_range(100),
                               {$urandom, $urandom}));
        end
        offer_item(mk_item(OP_EXPIRE, TID_W'($urandom), {$urandom, $urandom}, '1));
    endtask

    // mostly well-formed traffic around a slowly advancing time base;
    // fields an operation ignores carry random noise
    task automatic random_item(output t_in_item it);
        int roll;
        roll        = $urandom_range(99);
        it.task_id  = TID_W'($urandom_range(16'hFFFF));
        it.deadline = {$urandom, $urandom};
        it.now      = {$urandom, $urandom};
        if (roll < 40) begin
            it.op = OP_INSERT;
            // small id pool makes duplicate ids common
            if ($urandom_range(1) != 0) it.task_id = TID_W'($urandom_range(15));
            case ($urandom_range(4))
                0: ;                                    // full-range deadline
                1: it.deadline = last_deadline;         // tie with the previous insert
                default: it.deadline = sim_now + $urandom_range(3000);
            endcase
            last_deadline = it.deadline;
            recent_ids.push_back(it.task_id);
            if (recent_ids.size() > 48) recent_ids.delete(0);
        end else if (roll < 58) begin
            it.op = OP_CANCEL;
            if (recent_ids.size() != 0 && $urandom_range(3) != 0) begin
                it.task_id = recent_ids[$urandom_range(recent_ids.size() - 1)];
            end
        end else if (roll < 78) begin
            it.op   = OP_EXPIRE;
            sim_now = sim_now + $urandom_range(1500);
            if ($urandom_range(9) != 0) it.now = sim_now;
        end else begin
            it.op = OP_QUERY;
            if ($urandom_range(9) != 0) it.now = sim_now + $urandom_range(400) - 200;
        end
    endtask

    initial begin
        t_in_item it;
        int       phase;
        int       phase_end;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty store behavior
        offer_item(mk_item(OP_QUERY,  16'h0000, '0, '0));
        offer_item(mk_item(OP_EXPIRE, 16'h0000, '0, '1));
        offer_item(mk_item(OP_CANCEL, 16'h0000, '0, '0));
        // extremes of id and deadline, then three equal deadlines
        offer_item(mk_item(OP_INSERT, 16'hFFFF, '1, '0));
        offer_item(mk_item(OP_INSERT, 16'h0000, '0, '1));
        offer_item(mk_item(OP_INSERT, 16'h0001, 64'd500, '0));
        offer_item(mk_item(OP_INSERT, 16'h0002, 64'd500, '0));
        offer_item(mk_item(OP_INSERT, 16'h0003, 64'd500, '0));
        offer_item(mk_item(OP_QUERY,  16'h0000, '0, '0));
        offer_item(mk_item(OP_EXPIRE, 16'h0000, '0, '0));
        offer_item(mk_item(OP_QUERY,  16'h0000, '0, 64'd499));
        // overdue front clamps the delay at zero
        offer_item(mk_item(OP_QUERY,  16'h0000, '0, 64'd501));
        offer_item(mk_item(OP_CANCEL, 16'h0002, '0, '0));
        offer_item(mk_item(OP_CANCEL, 16'h1234, '0, '0));
        offer_item(mk_item(OP_CANCEL, 16'hFFFF, '0, '0));
        // one short of due, then the two tied entries in insertion order
        offer_item(mk_item(OP_EXPIRE, 16'h0000, '0, 64'd499));
        offer_item(mk_item(OP_EXPIRE, 16'h0000, '0, 64'd500));
        offer_item(mk_item(OP_INSERT, 16'hAAAA, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
        offer_item(mk_item(OP_INSERT, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
        offer_item(mk_item(OP_QUERY,  16'h0000, '0, '1));
        offer_item(mk_item(OP_EXPIRE, 16'h0000, '0, '1));

        // idle delay extremes, each seen by a query on the empty store
        settle();
        write_idle_delay('0);
        offer_item(mk_item(OP_QUERY, 16'h0000, '0, '0));
        settle();
        write_idle_delay('1);
        offer_item(mk_item(OP_QUERY, 16'h0000, '0, '1));

        // random phases: sender/receiver idle 19/78, then 78/19, then none
        for (phase = 0; phase < 3; phase++) begin
            settle();
            if (phase == 1) begin
                send_idle_pct = 78;
                recv_idle_pct <= 19;
                write_idle_delay({$urandom, $urandom});
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
                write_idle_delay(IDLE_DELAY_RST);
            end
            phase_end = items_sent + PHASE_ITEMS;
            fill_and_flush();
            // with no idling, hold the receiver off while items keep coming
            if (phase == 2) hold_ticket <= hold_ticket + 1;
            while (items_sent < phase_end) begin
                random_item(it);
                offer_item(it);
            end
        end

        // drain and give the verdict
        settle();
        $display("summary: %0d timer operations under three idle mixes, %0d results checked,",
                 items_sent, result_count);
        $display("summary: idle_delay written and read back %0d times, long receiver hold-off once",
                 cfg_writes);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // run limit well beyond the slowest correct run
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", pending);
        $display("testbench: FAIL");
        $finish;
    end

endmodule
